/* design/tcpck_pkg.sv */
// Shared types, constants and ones' complement helpers for the IPv4/TCP checksum engine.
`default_nettype none

package tcpck_pkg;

    // Status codes of a finished packet
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNC     = 2'd1;
    localparam logic [1:0] STATUS_SHORT_HDR = 2'd2;

    // Byte positions within the packet and the segment
    localparam logic [15:0] LEN_SEEN_BYTES = 16'd4;   // bytes 0..3 always taken
    localparam logic [15:0] HDR_CSUM_POS   = 16'd10;  // IP header checksum word
    localparam logic [15:0] TCP_CSUM_POS   = 16'd16;  // TCP checksum word, segment relative
    localparam logic [15:0] ADDR_FIRST_POS = 16'd12;  // first address word
    localparam logic [15:0] ADDR_LAST_POS  = 16'd18;  // last address word
    localparam logic [15:0] TCP_PROTO      = 16'd6;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // Packet state captured on the last byte, handed to the finishing stage
    typedef struct packed {
        logic [15:0] count;
        logic [5:0]  hdr_len;
        logic [15:0] total_len;
        logic [15:0] hdr_sum;
        logic [15:0] seg_sum;
        logic [7:0]  hold;
    } t_snap;

    // Fold a sum of up to eight 16-bit terms with end-around carry
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        return t[15:0] + {15'b0, t[16]};
    endfunction

    // Word at even position w belongs to the IP header sum
    function automatic logic route_hdr(input logic [15:0] w, input logic [5:0] hl);
        return (w < {10'b0, hl}) && (w != HDR_CSUM_POS);
    endfunction

    // Word at even position w belongs to the TCP segment sum
    function automatic logic route_seg(input logic [15:0] w, input logic [5:0] hl);
        logic [15:0] rel;
        rel = w - {10'b0, hl};
        return (w >= {10'b0, hl}) && (rel != TCP_CSUM_POS);
    endfunction

    // Word at even position w is an address word of the pseudo header
    function automatic logic route_pseudo(input logic [15:0] w);
        return (w >= ADDR_FIRST_POS) && (w <= ADDR_LAST_POS);
    endfunction

endpackage

`default_nettype wire

/* design/tcpck_finish.sv */
// Finishing stage: odd-byte padding, pseudo header terms, status and the result register.
`default_nettype none

module tcpck_finish (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_snap_valid,
    input  tcpck_pkg::t_snap    i_snap,
    output logic                o_take,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_ip_header_checksum,
    output logic [15:0]         o_tcp_checksum,
    output logic [1:0]          o_status
);

    logic        r_valid;
    logic [15:0] r_ip_csum;
    logic [15:0] r_tcp_csum;
    logic [1:0]  r_status;

    logic [15:0] lim;
    logic [15:0] end_pos;
    logic        pad;
    logic [15:0] pad_pos;
    logic [15:0] pad_word;
    logic [15:0] tcp_len;
    logic [15:0] w_h;
    logic [15:0] w_s;
    logic [15:0] w_p;
    logic [15:0] n_ip_csum;
    logic [15:0] n_tcp_csum;
    logic [1:0]  n_status;

    assign o_take = i_snap_valid && (!r_valid || i_ready);

    always_comb begin
        lim     = (i_snap.total_len < tcpck_pkg::LEN_SEEN_BYTES) ?
                  tcpck_pkg::LEN_SEEN_BYTES : i_snap.total_len;
        end_pos = (i_snap.count < lim) ? i_snap.count : lim;
        pad     = end_pos[0];
        pad_pos = {end_pos[15:1], 1'b0};
        pad_word = {i_snap.hold, 8'h00};
        tcp_len = i_snap.total_len - {10'b0, i_snap.hdr_len};

        w_h = (pad && tcpck_pkg::route_hdr(pad_pos, i_snap.hdr_len)) ? pad_word : 16'h0000;
        w_s = (pad && tcpck_pkg::route_seg(pad_pos, i_snap.hdr_len)) ? pad_word : 16'h0000;
        w_p = (pad && tcpck_pkg::route_pseudo(pad_pos)) ? pad_word : 16'h0000;

        n_ip_csum  = ~tcpck_pkg::oc_fold({3'b0, i_snap.hdr_sum} + {3'b0, w_h});
        n_tcp_csum = ~tcpck_pkg::oc_fold({3'b0, i_snap.seg_sum} + {3'b0, w_s}
                                         + {3'b0, w_p} + {3'b0, tcpck_pkg::TCP_PROTO}
                                         + {3'b0, tcp_len});

        if (i_snap.hdr_len < tcpck_pkg::MIN_HDR_BYTES) begin
            n_status = tcpck_pkg::STATUS_SHORT_HDR;
        end else if ((i_snap.count < tcpck_pkg::LEN_SEEN_BYTES) ||
                     (i_snap.count < i_snap.total_len)) begin
            n_status = tcpck_pkg::STATUS_TRUNC;
        end else begin
            n_status = tcpck_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ip_csum  <= n_ip_csum;
            r_tcp_csum <= n_tcp_csum;
            r_status   <= n_status;
        end
    end

    assign o_valid              = r_valid;
    assign o_ip_header_checksum = r_ip_csum;
    assign o_tcp_checksum       = r_tcp_csum;
    assign o_status             = r_status;

endmodule

`default_nettype wire

/* design/ipv4_tcp_checksum_engine.sv */
// Top level of the IPv4/TCP checksum engine: byte intake, running sums and result pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------------
//  input   | in        | i_valid / o_ready  | i_data_byte, i_last_byte
//  result  | out       | o_valid / i_ready  | o_ip_header_checksum, o_tcp_checksum, o_status
//
//  One byte is taken every cycle while o_ready is high; each byte within the total length folds
//  into the running sums in the cycle it is taken. A result passes from its last byte through the
//  snapshot register, then the finishing stage that adds padding and pseudo header terms.
//  Reset is synchronous, active low, and clears the packet state and both valid flags.
//  A stall on the result side holds the finishing stage, then the snapshot register; while a
//  snapshot waits for the finishing stage the input is held, whether the byte is last or not.
`default_nettype none

module ipv4_tcp_checksum_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_ip_header_checksum,
    output logic [15:0] o_tcp_checksum,
    output logic [1:0]  o_status
);

    logic [15:0] r_count;
    logic [5:0]  r_hdr_len;
    logic [15:0] r_total_len;
    logic [15:0] r_hdr_sum;
    logic [15:0] r_seg_sum;
    logic [7:0]  r_hold;
    logic        r_fin_valid;
    tcpck_pkg::t_snap r_snap;

    logic [15:0] n_count;
    logic [5:0]  n_hdr_len;
    logic [15:0] n_total_len;
    logic [15:0] n_hdr_sum;
    logic [15:0] n_seg_sum;
    logic [7:0]  n_hold;

    logic        in_acc;
    logic        fin_take;
    logic        sat;
    logic        taken;
    logic        odd;
    logic [15:0] w_pos;
    logic [15:0] word;
    logic [15:0] w_h;
    logic [15:0] w_s;
    logic [15:0] w_p;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = !r_fin_valid || fin_take;

    always_comb begin
        sat   = (r_count == tcpck_pkg::COUNT_MAX);
        taken = !sat && ((r_count < tcpck_pkg::LEN_SEEN_BYTES) || (r_count < r_total_len));
        odd   = taken && r_count[0];
        w_pos = {r_count[15:1], 1'b0};
        word  = {r_hold, i_data_byte};

        n_hdr_len = (taken && (r_count == 16'd0)) ? {i_data_byte[3:0], 2'b00} : r_hdr_len;
        n_total_len = r_total_len;
        if (taken && (r_count == 16'd2)) begin
            n_total_len = {i_data_byte, r_total_len[7:0]};
        end else if (taken && (r_count == 16'd3)) begin
            n_total_len = {r_total_len[15:8], i_data_byte};
        end
        n_hold = (taken && !r_count[0]) ? i_data_byte : r_hold;

        w_h = (odd && tcpck_pkg::route_hdr(w_pos, r_hdr_len)) ? word : 16'h0000;
        w_s = (odd && tcpck_pkg::route_seg(w_pos, r_hdr_len)) ? word : 16'h0000;
        w_p = (odd && tcpck_pkg::route_pseudo(w_pos)) ? word : 16'h0000;

        n_hdr_sum = tcpck_pkg::oc_fold({3'b0, r_hdr_sum} + {3'b0, w_h});
        n_seg_sum = tcpck_pkg::oc_fold({3'b0, r_seg_sum} + {3'b0, w_s} + {3'b0, w_p});
        n_count   = sat ? r_count : r_count + 16'd1;
    end

    // Packet state: advance per item, drop back to start after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 16'd0;
            r_hdr_len   <= 6'd0;
            r_total_len <= 16'd0;
            r_hdr_sum   <= 16'd0;
            r_seg_sum   <= 16'd0;
            r_hold      <= 8'd0;
            r_fin_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_last_byte) begin
                    r_count     <= 16'd0;
                    r_hdr_len   <= 6'd0;
                    r_total_len <= 16'd0;
                    r_hdr_sum   <= 16'd0;
                    r_seg_sum   <= 16'd0;
                    r_hold      <= 8'd0;
                end else begin
                    r_count     <= n_count;
                    r_hdr_len   <= n_hdr_len;
                    r_total_len <= n_total_len;
                    r_hdr_sum   <= n_hdr_sum;
                    r_seg_sum   <= n_seg_sum;
                    r_hold      <= n_hold;
                end
            end
            if (in_acc && i_last_byte) begin
                r_fin_valid <= 1'b1;
            end else if (fin_take) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_snap.count     <= n_count;
            r_snap.hdr_len   <= n_hdr_len;
            r_snap.total_len <= n_total_len;
            r_snap.hdr_sum   <= n_hdr_sum;
            r_snap.seg_sum   <= n_seg_sum;
            r_snap.hold      <= n_hold;
        end
    end

    tcpck_finish u_finish (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_snap_valid         (r_fin_valid),
        .i_snap               (r_snap),
        .o_take               (fin_take),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_ip_header_checksum (o_ip_header_checksum),
        .o_tcp_checksum       (o_tcp_checksum),
        .o_status             (o_status)
    );

`ifndef SYNTH
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> (r_count == 16'd0) && r_fin_valid)
        else $error("packet state not restarted after last item");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_last_byte && (r_count != tcpck_pkg::COUNT_MAX))
        |=> (r_count == $past(r_count) + 16'd1))
        else $error("byte count did not advance on an accepted item");

    a_snapshot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !fin_take) |=> (r_fin_valid && $stable(r_snap)))
        else $error("pending snapshot lost or changed while stalled");

    a_hdr_len_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_len[1:0] == 2'b00))
        else $error("header length not a whole number of words");
`endif

endmodule

`default_nettype wire
